// ===== design/cbr_pkg.sv =====
package cbr_pkg;

	localparam int ADDR_W  = 17;
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int TAG_W   = 10;
	localparam int FIELD_W = 5;
	localparam int LANE_W  = 2;
	localparam int TAG_LSB = 7;
	localparam int SET_LSB = 2;
	localparam int FIELD_N = 32;

	// one row of the tag store: both ways of a set plus its age mark
	typedef struct packed {
		logic [TAG_W-1:0] tag1;
		logic [TAG_W-1:0] tag0;
		logic [1:0]       valid;
		logic             newest;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	typedef logic [LANE_W-1:0] lane_t;

	localparam lane_t LANE0 = 2'd0;
	localparam lane_t LANE1 = 2'd1;
	localparam lane_t LANE2 = 2'd2;
	localparam lane_t LANE3 = 2'd3;

	function automatic logic [BYTE_W-1:0] lane_of(input logic [WORD_W-1:0] word,
			input lane_t lane);
		logic [BYTE_W-1:0] b;
		case (lane)
			LANE0: b = word[7:0];
			LANE1: b = word[15:8];
			LANE2: b = word[23:16];
			LANE3: b = word[31:24];
			default: b = word[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== design/cbr_ram.sv =====
module cbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/two_way_cache_byte_read_core.sv =====
// channel  | handshake          | fields
// ---------+--------------------+-------------------------------
// request  | start, busy        | byte_addr[16:0], fill_word[31:0]
// result   | done (1-cycle)     | data_byte[7:0], from_memory
//
// Each word goes through a tag/line RAM read, then compare and write back.
// done pulses the cycle after the compare; a new request is taken that cycle.
// After reset a clearing pass walks every set of the tag RAM with busy high.
// A new request is taken only in idle, so a word finishes its compare before the next one.
// The receiver cannot stall; results are never held.
module two_way_cache_byte_read_core #(
	parameter int SET_COUNT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [cbr_pkg::ADDR_W-1:0]  byte_addr,
	input  logic [cbr_pkg::WORD_W-1:0]  fill_word,
	output logic                        done,
	output logic [cbr_pkg::BYTE_W-1:0]  data_byte,
	output logic                        from_memory
);

	localparam int SW = $clog2(SET_COUNT);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_q;
	logic [cbr_pkg::TAG_W-1:0] tag_q;
	cbr_pkg::lane_t lane_q;
	logic [cbr_pkg::WORD_W-1:0] fill_q;
	logic done_q;
	logic from_mem_q;
	logic [cbr_pkg::BYTE_W-1:0] byte_q;

	// 5-bit set field folded onto SET_COUNT sets
	logic [SW-1:0] set_map [cbr_pkg::FIELD_N];
	for (genvar g = 0; g < cbr_pkg::FIELD_N; g++) begin : g_map
		assign set_map[g] = SW'(g % SET_COUNT);
	end

	logic accept;
	logic [SW-1:0] set_in;
	assign accept = start && (state_q == ST_IDLE);
	assign set_in = set_map[byte_addr[cbr_pkg::TAG_LSB-1:cbr_pkg::SET_LSB]];

	logic meta_we;
	logic [SW-1:0] meta_waddr;
	cbr_pkg::meta_t meta_wr;
	logic [cbr_pkg::META_W-1:0] meta_rdata;
	cbr_pkg::meta_t meta_rd;
	logic line_we;
	logic [2*cbr_pkg::WORD_W-1:0] line_wr;
	logic [2*cbr_pkg::WORD_W-1:0] line_rd;

	cbr_ram #(.WIDTH(cbr_pkg::META_W), .DEPTH(SET_COUNT)) u_meta (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wr),
		.re   (accept),
		.raddr(set_in),
		.rdata(meta_rdata)
	);

	cbr_ram #(.WIDTH(2*cbr_pkg::WORD_W), .DEPTH(SET_COUNT)) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(set_q),
		.wdata(line_wr),
		.re   (accept),
		.raddr(set_in),
		.rdata(line_rd)
	);

	assign meta_rd = cbr_pkg::meta_t'(meta_rdata);

	logic hit0, hit1, hit, victim;
	logic [cbr_pkg::WORD_W-1:0] word0, word1, hit_word;

	always_comb begin
		word0 = line_rd[cbr_pkg::WORD_W-1:0];
		word1 = line_rd[2*cbr_pkg::WORD_W-1:cbr_pkg::WORD_W];
		hit0 = meta_rd.valid[0] && (meta_rd.tag0 == tag_q);
		hit1 = meta_rd.valid[1] && (meta_rd.tag1 == tag_q);
		hit = hit0 || hit1;
		hit_word = hit0 ? word0 : word1;
		// fill invalid ways first, else evict the older one
		if (!meta_rd.valid[0]) begin
			victim = 1'b0;
		end else if (!meta_rd.valid[1]) begin
			victim = 1'b1;
		end else begin
			victim = !meta_rd.newest;
		end

		meta_wr = meta_rd;
		line_wr = line_rd;
		if (victim) begin
			meta_wr.tag1 = tag_q;
			meta_wr.valid[1] = 1'b1;
			line_wr[2*cbr_pkg::WORD_W-1:cbr_pkg::WORD_W] = fill_q;
		end else begin
			meta_wr.tag0 = tag_q;
			meta_wr.valid[0] = 1'b1;
			line_wr[cbr_pkg::WORD_W-1:0] = fill_q;
		end
		meta_wr.newest = victim;

		meta_we = 1'b0;
		line_we = 1'b0;
		meta_waddr = set_q;
		if (state_q == ST_CLEAR) begin
			meta_we = 1'b1;
			meta_waddr = clr_q;
			meta_wr = '0;
		end else if (state_q == ST_LOOKUP && !hit) begin
			meta_we = 1'b1;
			line_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
			from_mem_q <= 1'b0;
			byte_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(SET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					done_q <= 1'b1;
					from_mem_q <= !hit;
					byte_q <= cbr_pkg::lane_of(hit ? hit_word : fill_q, lane_q);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_q <= set_in;
			tag_q <= byte_addr[cbr_pkg::ADDR_W-1:cbr_pkg::TAG_LSB];
			lane_q <= byte_addr[cbr_pkg::LANE_W-1:0];
			fill_q <= fill_word;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign data_byte = byte_q;
	assign from_memory = from_mem_q;

`ifndef SYNTHESIS
	a_one_way_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |-> !(hit0 && hit1))
		else $error("both ways hit in one set");

	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_LOOKUP))
		else $error("result without a lookup");

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted word produced no result");

	a_no_write_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && hit) |-> !line_we && !meta_we)
		else $error("cache written on a hit");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS         = 32;
	localparam int RANDOM_ITEMS = 1630;

	typedef struct packed {
		logic [cbr_pkg::BYTE_W-1:0] data_byte;
		logic                       from_memory;
	} read_word_t;

	class cache_read_checker;
		logic [cbr_pkg::TAG_W-1:0]  tags  [2*SETS];
		logic [cbr_pkg::WORD_W-1:0] words [2*SETS];
		bit                         valid [2*SETS];
		bit                         newest[SETS];
		read_word_t                 expected_reads[$];
		int                         mismatches;

		function new();
			foreach (tags[i]) begin
				tags[i]  = '0;
				words[i] = '0;
				valid[i] = 1'b0;
			end
			foreach (newest[i])
				newest[i] = 1'b0;
			mismatches = 0;
		endfunction

		task report_mismatch(string what);
			if (mismatches < 40)
				$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// an accepted access: look up both ways, fill FIFO-style on a miss
		function void note_access(logic [cbr_pkg::ADDR_W-1:0] addr,
				logic [cbr_pkg::WORD_W-1:0] word);
			int unsigned                set_no;
			int unsigned                w0;
			int unsigned                slot;
			logic [cbr_pkg::TAG_W-1:0]  tag;
			logic [cbr_pkg::LANE_W-1:0] lane;
			bit                         hit0;
			bit                         hit1;
			bit                         victim;
			read_word_t                 r;
			lane   = addr[cbr_pkg::LANE_W-1:0];
			set_no = addr[cbr_pkg::SET_LSB +: cbr_pkg::FIELD_W] % SETS;
			tag    = addr[cbr_pkg::TAG_LSB +: cbr_pkg::TAG_W];
			w0     = 2 * set_no;
			hit0   = valid[w0] && tags[w0] == tag;
			hit1   = valid[w0+1] && tags[w0+1] == tag;
			if (hit0 || hit1) begin
				slot          = hit0 ? w0 : w0 + 1;
				r.data_byte   = cbr_pkg::lane_of(words[slot], lane);
				r.from_memory = 1'b0;
			end else begin
				if (!valid[w0])
					victim = 1'b0;
				else if (!valid[w0+1])
					victim = 1'b1;
				else
					victim = !newest[set_no];
				slot           = w0 + victim;
				words[slot]    = word;
				tags[slot]     = tag;
				valid[slot]    = 1'b1;
				newest[set_no] = victim;
				r.data_byte    = cbr_pkg::lane_of(word, lane);
				r.from_memory  = 1'b1;
			end
			expected_reads.push_back(r);
		endfunction

		task check_read(logic [cbr_pkg::BYTE_W-1:0] got_byte, logic got_mem);
			read_word_t want;
			if (expected_reads.size() == 0) begin
				report_mismatch($sformatf("unexpected word: byte %02h from_memory %b",
					got_byte, got_mem));
			end else begin
				want = expected_reads.pop_front();
				if (got_byte !== want.data_byte)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						got_byte, want.data_byte));
				if (got_mem !== want.from_memory)
					report_mismatch($sformatf("from_memory %b, expected %b",
						got_mem, want.from_memory));
			end
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [cbr_pkg::ADDR_W-1:0]   byte_addr;
	logic [cbr_pkg::WORD_W-1:0]   fill_word;
	logic                         done;
	logic [cbr_pkg::BYTE_W-1:0]   data_byte;
	logic                         from_memory;

	cache_read_checker   reads;
	bit                  steady;

	two_way_cache_byte_read_core #(
		.SET_COUNT(SETS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.byte_addr(byte_addr),
		.fill_word(fill_word),
		.done(done),
		.data_byte(data_byte),
		.from_memory(from_memory)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			reads.check_read(data_byte, from_memory);
	end

	function automatic logic [cbr_pkg::ADDR_W-1:0] addr_of(logic [cbr_pkg::TAG_W-1:0] tag,
			logic [cbr_pkg::FIELD_W-1:0] set_no, logic [cbr_pkg::LANE_W-1:0] lane);
		return {tag, set_no, lane};
	endfunction

	task automatic send_read(input logic [cbr_pkg::ADDR_W-1:0] addr,
			input logic [cbr_pkg::WORD_W-1:0] word);
		if (!steady && $urandom_range(99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		start     <= 1'b1;
		byte_addr <= addr;
		fill_word <= word;
		do @(posedge clk); while (busy !== 1'b0);
		reads.note_access(addr, word);
	endtask

	// hold off the sender until every outstanding word has come back
	task automatic drain();
		start <= 1'b0;
		while (reads.expected_reads.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [cbr_pkg::TAG_W-1:0]   tag_pool[3];
		logic [cbr_pkg::FIELD_W-1:0] set_pool[4];
		logic [cbr_pkg::ADDR_W-1:0]  addr;
		reads     = new();
		steady    = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		byte_addr <= '0;
		fill_word <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// tag zero against a fresh set must still miss
		send_read(addr_of(10'h000, 5'd0, cbr_pkg::LANE0), 32'hFFFF_FFFF);
		send_read(addr_of(10'h000, 5'd0, cbr_pkg::LANE3), 32'h0000_0000);
		send_read(addr_of(10'h3FF, 5'd0, cbr_pkg::LANE1), 32'h0000_0000);
		send_read(addr_of(10'h3FF, 5'd0, cbr_pkg::LANE2), 32'hFFFF_FFFF);
		// hit on the older way must not refresh its age
		send_read(addr_of(10'h000, 5'd0, cbr_pkg::LANE1), 32'h1234_5678);
		send_read(addr_of(10'h005, 5'd0, cbr_pkg::LANE0), 32'hA5C3_5A3C);
		send_read(addr_of(10'h000, 5'd0, cbr_pkg::LANE2), 32'h8765_4321);
		send_read(addr_of(10'h005, 5'd0, cbr_pkg::LANE3), 32'h0000_0000);
		send_read(addr_of(10'h3FF, 5'd0, cbr_pkg::LANE1), 32'h5A5A_A5A5);
		send_read(addr_of(10'h000, 5'd0, cbr_pkg::LANE0), 32'hC001_D00D);
		send_read(17'h1FFFF, 32'h1234_5678);
		send_read(17'h1FFFC, 32'hFFFF_FFFF);
		send_read(addr_of(10'h000, 5'd31, cbr_pkg::LANE0), 32'hDEAD_BEEF);
		send_read(addr_of(10'h000, 5'd31, cbr_pkg::LANE2), 32'h0000_0000);
		send_read(addr_of(10'h2AA, 5'd31, cbr_pkg::LANE1), 32'hCAFE_F00D);
		send_read(addr_of(10'h3FF, 5'd31, cbr_pkg::LANE3), 32'h0000_0000);
		send_read(addr_of(10'h155, 5'd21, cbr_pkg::LANE2), 32'h0F0F_F0F0);
		send_read(addr_of(10'h155, 5'd21, cbr_pkg::LANE1), 32'hFFFF_FFFF);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0) begin
				foreach (tag_pool[k])
					tag_pool[k] = cbr_pkg::TAG_W'($urandom_range(1023));
				foreach (set_pool[k])
					set_pool[k] = cbr_pkg::FIELD_W'($urandom_range(31));
			end
			steady = (i >= 300 && i < 600);
			if (i == 800)
				drain();
			if ($urandom_range(99) < 75)
				addr = addr_of(tag_pool[$urandom_range(2)], set_pool[$urandom_range(3)],
					cbr_pkg::LANE_W'($urandom_range(3)));
			else
				addr = cbr_pkg::ADDR_W'($urandom_range(17'h1FFFF));
			send_read(addr, $urandom);
		end
		drain();
		repeat (8) @(posedge clk);

		if (reads.mismatches == 0 && reads.expected_reads.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== two_way_cache_byte_read_core.f =====
design/cbr_pkg.sv
design/cbr_ram.sv
design/two_way_cache_byte_read_core.sv
tb/tb_top.sv
